// ===== rtl/scmap_pkg.sv =====
package scmap_pkg;

  localparam int T_FRAC = 30;
  localparam logic signed [31:0] T_ONE = 32'sd1073741824;
  // any value above one keeps every decision that a larger quotient would make
  localparam logic signed [31:0] T_ABOVE = 32'sd1073741825;
  localparam logic signed [31:0] T_BELOW = -32'sd1;

  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_SCALE_X     = 3'd4,
    REG_SCALE_Y     = 3'd5,
    REG_OFFSET_X    = 3'd6,
    REG_OFFSET_Y    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] clip_left;
    logic signed [31:0] clip_top;
    logic signed [31:0] clip_right;
    logic signed [31:0] clip_bottom;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } seg_t;

  typedef struct packed {
    logic        begin_subpath;
    logic [31:0] screen_x0;
    logic [31:0] screen_y0;
    logic [31:0] screen_x1;
    logic [31:0] screen_y1;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/scmap_fifo.sv =====
module scmap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= wdata;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/scmap_front.sv =====
module scmap_front (
  input  logic                clk,
  input  logic                rst_n,
  input  scmap_pkg::cfg_t     cfg,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_start_x,
  input  logic signed [31:0]  in_start_y,
  input  logic signed [31:0]  in_end_x,
  input  logic signed [31:0]  in_end_y,
  output logic                q_push,
  output scmap_pkg::seg_t     q_data,
  input  logic                q_full
);

  logic               valid_r;
  logic signed [31:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [32:0] dx, dy;
  logic               reject, advance;

  assign dx = {x1_r[31], x1_r} - {x0_r[31], x0_r};
  assign dy = {y1_r[31], y1_r} - {y0_r[31], y0_r};

  // a parallel edge with the segment outside it drops the item here
  assign reject = ((dx == '0) && ((x0_r < cfg.clip_left) || (x0_r > cfg.clip_right))) ||
                  ((dy == '0) && ((y0_r < cfg.clip_top) || (y0_r > cfg.clip_bottom)));

  assign advance = valid_r && (reject || !q_full);
  assign in_full = valid_r && !advance;
  assign q_push  = valid_r && !reject && !q_full;

  always_comb begin
    q_data.x0 = x0_r;
    q_data.y0 = y0_r;
    q_data.dx = dx;
    q_data.dy = dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        valid_r <= 1'b1;
        x0_r    <= in_start_x;
        y0_r    <= in_start_y;
        x1_r    <= in_end_x;
        y1_r    <= in_end_y;
      end else if (advance) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/scmap_div.sv =====
module scmap_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [32:0]   num,
  input  logic signed [32:0]   den,
  output scmap_pkg::div_stat_t stat,
  output logic signed [31:0]   quot
);

  logic        busy_r, done_r, neg_r, ovf_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r, dm_r;
  logic [30:0] q_r;
  logic [32:0] nm, dm;
  logic        ovf, b30;
  logic [33:0] rem2, sub;
  logic        ge;

  assign nm  = num[32] ? 33'(-num) : 33'(num);
  assign dm  = den[32] ? 33'(-den) : 33'(den);
  // quotient of two or more saturates, otherwise it has 31 bits
  assign ovf = {1'b0, nm} >= {dm, 1'b0};
  assign b30 = nm >= dm;

  assign rem2 = {rem_r, 1'b0};
  assign sub  = rem2 - {1'b0, dm_r};
  assign ge   = rem2 >= {1'b0, dm_r};

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_comb begin
    if (ovf_r) begin
      quot = neg_r ? scmap_pkg::T_BELOW : scmap_pkg::T_ABOVE;
    end else if (neg_r && (q_r != '0)) begin
      quot = scmap_pkg::T_BELOW;
    end else begin
      quot = {1'b0, q_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= (start && ovf) || (!start && busy_r && (cnt_r == 5'd1));
      if (start) begin
        neg_r  <= num[32] ^ den[32];
        ovf_r  <= ovf;
        dm_r   <= dm;
        rem_r  <= b30 ? nm - dm : nm;
        q_r    <= {30'b0, b30};
        cnt_r  <= 5'd30;
        busy_r <= !ovf;
      end else if (busy_r) begin
        rem_r <= ge ? sub[32:0] : rem2[32:0];
        q_r   <= {q_r[29:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/scmap_back.sv =====
module scmap_back #(
  parameter int SAT_W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  scmap_pkg::cfg_t cfg,
  input  logic            q_empty,
  input  scmap_pkg::seg_t q_data,
  output logic            q_pop,
  output logic            out_push,
  output scmap_pkg::res_t out_data,
  input  logic            out_full
);

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE, S_DIV, S_DECIDE, S_MUL_A, S_MUL_B, S_PUSH
  } state_t;

  localparam logic signed [66:0] RND30 = 67'sd536870912;
  localparam logic signed [66:0] RND16 = 67'sd32768;
  localparam logic signed [50:0] SAT_HI = 51'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [50:0] SAT_LO = -SAT_HI - 51'sd1;

  state_t              state_r;
  scmap_pkg::seg_t     seg_r;
  logic [1:0]          edge_r;
  logic [2:0]          k_r;
  logic                has_lo_r, has_hi_r, cut_r, prev_cut_r;
  logic signed [31:0]  t_lo_r, t_hi_r;
  logic [30:0]         tl_r, th_r;
  logic signed [66:0]  prod_r;
  logic signed [32:0]  pt_r [4];
  logic [31:0]         sc_r [4];

  logic signed [32:0]  u, v;
  logic                div_start;
  scmap_pkg::div_stat_t div_stat;
  logic signed [31:0]  div_q;
  logic                rej;
  logic [30:0]         tl_c, th_c, tsel;
  logic signed [33:0]  ma;
  logic signed [32:0]  mb;
  logic signed [66:0]  mprod, rnd30, rnd16;
  logic signed [32:0]  cp;
  logic signed [50:0]  scr, sat;
  logic signed [31:0]  edge_c;

  always_comb begin
    unique case (edge_r)
      2'd0: begin
        u = {seg_r.x0[31], seg_r.x0} - {cfg.clip_left[31], cfg.clip_left};
        v = -seg_r.dx;
      end
      2'd1: begin
        u = {cfg.clip_right[31], cfg.clip_right} - {seg_r.x0[31], seg_r.x0};
        v = seg_r.dx;
      end
      2'd2: begin
        u = {seg_r.y0[31], seg_r.y0} - {cfg.clip_top[31], cfg.clip_top};
        v = -seg_r.dy;
      end
      default: begin
        u = {cfg.clip_bottom[31], cfg.clip_bottom} - {seg_r.y0[31], seg_r.y0};
        v = seg_r.dy;
      end
    endcase
  end

  assign div_start = (state_r == S_EDGE) && (v != '0);

  scmap_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (u),
    .den   (v),
    .stat  (div_stat),
    .quot  (div_q)
  );

  assign rej = (has_lo_r && has_hi_r && (t_lo_r >= t_hi_r)) ||
               (has_hi_r && (t_hi_r < 0)) ||
               (has_lo_r && (t_lo_r > scmap_pkg::T_ONE));

  always_comb begin
    if (!has_lo_r || (t_lo_r < 0)) begin
      tl_c = '0;
    end else if (t_lo_r > scmap_pkg::T_ONE) begin
      tl_c = scmap_pkg::T_ONE[30:0];
    end else begin
      tl_c = t_lo_r[30:0];
    end
    if (!has_hi_r || (t_hi_r > scmap_pkg::T_ONE)) begin
      th_c = scmap_pkg::T_ONE[30:0];
    end else if (t_hi_r < 0) begin
      th_c = '0;
    end else begin
      th_c = t_hi_r[30:0];
    end
  end

  // steps 0..3 clip the points, steps 4..7 map them to the screen
  always_comb begin
    tsel   = k_r[1] ? th_r : tl_r;
    edge_c = k_r[0] ? cfg.clip_top : cfg.clip_left;
    if (!k_r[2]) begin
      ma = {3'b000, tsel};
      mb = k_r[0] ? seg_r.dy : seg_r.dx;
    end else begin
      ma = {pt_r[k_r[1:0]][32], pt_r[k_r[1:0]]} - {{2{edge_c[31]}}, edge_c};
      mb = k_r[0] ? {cfg.scale_y[31], cfg.scale_y} : {cfg.scale_x[31], cfg.scale_x};
    end
    mprod = ma * mb;
  end

  always_comb begin
    rnd30 = (prod_r + RND30) >>> scmap_pkg::T_FRAC;
    rnd16 = (prod_r + RND16) >>> 16;
    cp    = (k_r[0] ? {seg_r.y0[31], seg_r.y0} : {seg_r.x0[31], seg_r.x0}) + rnd30[32:0];
    scr   = rnd16[50:0] + (k_r[0] ? 51'(cfg.offset_y) : 51'(cfg.offset_x));
    if (scr > SAT_HI) begin
      sat = SAT_HI;
    end else if (scr < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = scr;
    end
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_push = (state_r == S_PUSH) && !out_full;

  always_comb begin
    out_data.begin_subpath = prev_cut_r;
    out_data.screen_x0     = sc_r[0];
    out_data.screen_y0     = sc_r[1];
    out_data.screen_x1     = sc_r[2];
    out_data.screen_y1     = sc_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      prev_cut_r <= 1'b0;
      edge_r     <= '0;
      k_r        <= '0;
      has_lo_r   <= 1'b0;
      has_hi_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            seg_r    <= q_data;
            edge_r   <= '0;
            has_lo_r <= 1'b0;
            has_hi_r <= 1'b0;
            state_r  <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (v != '0) begin
            state_r <= S_DIV;
          end else if (edge_r == 2'd3) begin
            state_r <= S_DECIDE;
          end else begin
            edge_r <= edge_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (v[32]) begin
              if (!has_lo_r || (div_q > t_lo_r)) t_lo_r <= div_q;
              has_lo_r <= 1'b1;
            end else begin
              if (!has_hi_r || (div_q < t_hi_r)) t_hi_r <= div_q;
              has_hi_r <= 1'b1;
            end
            if (edge_r == 2'd3) begin
              state_r <= S_DECIDE;
            end else begin
              edge_r  <= edge_r + 1'b1;
              state_r <= S_EDGE;
            end
          end
        end
        S_DECIDE: begin
          if (rej) begin
            state_r <= S_IDLE;
          end else begin
            tl_r    <= tl_c;
            th_r    <= th_c;
            cut_r   <= th_c != scmap_pkg::T_ONE[30:0];
            k_r     <= '0;
            state_r <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          prod_r  <= mprod;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          if (!k_r[2]) begin
            pt_r[k_r[1:0]] <= cp;
          end else begin
            sc_r[k_r[1:0]] <= sat[31:0];
          end
          if (k_r == 3'd7) begin
            state_r <= S_PUSH;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MUL_A;
          end
        end
        S_PUSH: begin
          if (!out_full) begin
            prev_cut_r <= cut_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_clamped_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_A) |-> (tl_r <= th_r))
    else $error("clipped parameters out of order");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider result with no edge waiting");

  a_push_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |=> (state_r == S_IDLE) && (prev_cut_r == $past(cut_r)))
    else $error("result push did not update subpath flag");

endmodule

// ===== rtl/segment_clip_and_screen_map_core.sv =====
// channel  | ports                                   | accepted when
// input    | in_push, in_full, in_start_*, in_end_*  | in_push && !in_full
// result   | out_pop, out_empty, out_begin_subpath,  | out_pop && !out_empty
//          | out_screen_x0/y0/x1/y1                  |
// config   | cfg_we, cfg_index, cfg_wdata            | cfg_we
//
// in the back end most of a segment's time goes to the shared bit-serial
// divider, run once for each edge not parallel to the segment (it ends early
// when the quotient overflows); the rest goes to the mapping and to take, decide, push
// reset is synchronous and clears the queues and the subpath flag
// the front stage and a two-entry queue take new segments while the back works
// a two-entry result queue lets the back finish while out_pop is low
module segment_clip_and_screen_map_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic               out_pop,
  output logic               out_empty,
  output logic               out_begin_subpath,
  output logic signed [31:0] out_screen_x0,
  output logic signed [31:0] out_screen_y0,
  output logic signed [31:0] out_screen_x1,
  output logic signed [31:0] out_screen_y1
);

  localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int SEG_W = $bits(scmap_pkg::seg_t);
  localparam int RES_W = $bits(scmap_pkg::res_t);

  scmap_pkg::cfg_t cfg_r;
  scmap_pkg::seg_t fq_wdata, fq_rdata;
  scmap_pkg::res_t rq_wdata, rq_rdata;
  logic            fq_push, fq_full, fq_pop, fq_empty;
  logic            rq_push, rq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= 32'sd0;
      cfg_r.clip_top    <= 32'sd0;
      cfg_r.clip_right  <= 32'sd65536;
      cfg_r.clip_bottom <= 32'sd65536;
      cfg_r.scale_x     <= 32'sd65536;
      cfg_r.scale_y     <= 32'sd65536;
      cfg_r.offset_x    <= 32'sd0;
      cfg_r.offset_y    <= 32'sd0;
    end else if (cfg_we) begin
      unique case (scmap_pkg::cfg_idx_t'(cfg_index))
        scmap_pkg::REG_CLIP_LEFT:   cfg_r.clip_left   <= cfg_wdata;
        scmap_pkg::REG_CLIP_TOP:    cfg_r.clip_top    <= cfg_wdata;
        scmap_pkg::REG_CLIP_RIGHT:  cfg_r.clip_right  <= cfg_wdata;
        scmap_pkg::REG_CLIP_BOTTOM: cfg_r.clip_bottom <= cfg_wdata;
        scmap_pkg::REG_SCALE_X:     cfg_r.scale_x     <= cfg_wdata;
        scmap_pkg::REG_SCALE_Y:     cfg_r.scale_y     <= cfg_wdata;
        scmap_pkg::REG_OFFSET_X:    cfg_r.offset_x    <= cfg_wdata;
        scmap_pkg::REG_OFFSET_Y:    cfg_r.offset_y    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  scmap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_push     (fq_push),
    .q_data     (fq_wdata),
    .q_full     (fq_full)
  );

  scmap_fifo #(.WIDTH(SEG_W), .DEPTH(2)) u_seg_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  scmap_back #(.SAT_W(SAT_W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (fq_empty),
    .q_data   (fq_rdata),
    .q_pop    (fq_pop),
    .out_push (rq_push),
    .out_data (rq_wdata),
    .out_full (rq_full)
  );

  scmap_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_begin_subpath = rq_rdata.begin_subpath;
  assign out_screen_x0     = rq_rdata.screen_x0;
  assign out_screen_y0     = rq_rdata.screen_y0;
  assign out_screen_x1     = rq_rdata.screen_x1;
  assign out_screen_y1     = rq_rdata.screen_y1;

endmodule

// ===== tb/segment_clip_and_screen_map_checker.sv =====
module segment_clip_and_screen_map_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  input  logic               in_full,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic               out_pop,
  input  logic               out_empty,
  input  logic               out_begin_subpath,
  input  logic signed [31:0] out_screen_x0,
  input  logic signed [31:0] out_screen_y0,
  input  logic signed [31:0] out_screen_x1,
  input  logic signed [31:0] out_screen_y1,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  scmap_pkg::cfg_t win;
  bit              cut_short;
  scmap_pkg::res_t screen_q[$];

  assign pending = screen_q.size();

  function automatic logic [31:0] map_axis(longint p, longint edge_pos, longint scale,
                                           longint offset);
    longint r;
    r = (((p - edge_pos) * scale + 64'sd32768) >>> 16) + offset;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // returns 1 when the segment survives clipping; updates the subpath flag
  function automatic bit clip_and_map(input logic signed [31:0] sx, sy, ex, ey,
                                      output scmap_pkg::res_t r);
    longint x0, y0, dx, dy, lo, hi, t;
    longint v[4], u[4];
    bit has_lo, has_hi;
    x0 = sx; y0 = sy;
    dx = longint'(ex) - x0;
    dy = longint'(ey) - y0;
    v[0] = -dx; u[0] = x0 - longint'(win.clip_left);
    v[1] = dx;  u[1] = longint'(win.clip_right) - x0;
    v[2] = -dy; u[2] = y0 - longint'(win.clip_top);
    v[3] = dy;  u[3] = longint'(win.clip_bottom) - y0;
    has_lo = 0; has_hi = 0; lo = 0; hi = 0; r = '0;
    for (int i = 0; i < 4; i++) begin
      if (v[i] == 0) begin
        if (u[i] < 0) return 0;
      end else begin
        t = (u[i] * (64'sd1 << scmap_pkg::T_FRAC)) / v[i];
        if (v[i] < 0) begin
          if (!has_lo || t > lo) lo = t;
          has_lo = 1;
        end else begin
          if (!has_hi || t < hi) hi = t;
          has_hi = 1;
        end
      end
    end
    if (has_lo && has_hi && lo >= hi) return 0;
    if (has_hi && hi < 0) return 0;
    if (has_lo && lo > longint'(scmap_pkg::T_ONE)) return 0;
    if (!has_lo || lo < 0) lo = 0;
    if (lo > longint'(scmap_pkg::T_ONE)) lo = scmap_pkg::T_ONE;
    if (!has_hi || hi > longint'(scmap_pkg::T_ONE)) hi = scmap_pkg::T_ONE;
    if (hi < 0) hi = 0;
    r.begin_subpath = cut_short;
    r.screen_x0 = map_axis(x0 + ((lo * dx + (64'sd1 << 29)) >>> scmap_pkg::T_FRAC),
                           win.clip_left, win.scale_x, win.offset_x);
    r.screen_y0 = map_axis(y0 + ((lo * dy + (64'sd1 << 29)) >>> scmap_pkg::T_FRAC),
                           win.clip_top, win.scale_y, win.offset_y);
    r.screen_x1 = map_axis(x0 + ((hi * dx + (64'sd1 << 29)) >>> scmap_pkg::T_FRAC),
                           win.clip_left, win.scale_x, win.offset_x);
    r.screen_y1 = map_axis(y0 + ((hi * dy + (64'sd1 << 29)) >>> scmap_pkg::T_FRAC),
                           win.clip_top, win.scale_y, win.offset_y);
    cut_short = hi < longint'(scmap_pkg::T_ONE);
    return 1;
  endfunction

  always @(posedge clk) begin
    scmap_pkg::res_t exp_r, got_r;
    if (!rst_n) begin
      win <= '{clip_left: 0, clip_top: 0, clip_right: 32'sd65536, clip_bottom: 32'sd65536,
               scale_x: 32'sd65536, scale_y: 32'sd65536, offset_x: 0, offset_y: 0};
      cut_short = 0;
      screen_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (scmap_pkg::cfg_idx_t'(cfg_index))
          scmap_pkg::REG_CLIP_LEFT:   win.clip_left   <= cfg_wdata;
          scmap_pkg::REG_CLIP_TOP:    win.clip_top    <= cfg_wdata;
          scmap_pkg::REG_CLIP_RIGHT:  win.clip_right  <= cfg_wdata;
          scmap_pkg::REG_CLIP_BOTTOM: win.clip_bottom <= cfg_wdata;
          scmap_pkg::REG_SCALE_X:     win.scale_x     <= cfg_wdata;
          scmap_pkg::REG_SCALE_Y:     win.scale_y     <= cfg_wdata;
          scmap_pkg::REG_OFFSET_X:    win.offset_x    <= cfg_wdata;
          scmap_pkg::REG_OFFSET_Y:    win.offset_y    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (clip_and_map(in_start_x, in_start_y, in_end_x, in_end_y, exp_r))
          screen_q.push_back(exp_r);
      end
      if (out_pop && !out_empty) begin
        got_r = '{out_begin_subpath, out_screen_x0, out_screen_y0, out_screen_x1,
                  out_screen_y1};
        if (screen_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result %h at %0t", got_r, $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = screen_q.pop_front();
          if (got_r !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch at %0t: begin exp %b got %b,", $realtime,
                       exp_r.begin_subpath, got_r.begin_subpath,
                       " x0 exp %h got %h, y0 exp %h got %h,",
                       exp_r.screen_x0, got_r.screen_x0, exp_r.screen_y0, got_r.screen_y0,
                       " x1 exp %h got %h, y1 exp %h got %h",
                       exp_r.screen_x1, got_r.screen_x1, exp_r.screen_y1, got_r.screen_y1);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/segment_clip_and_screen_map_core_test.sv =====
module segment_clip_and_screen_map_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SETTLE = 1000;
  localparam int  CYCLE_LIMIT = 1500000;
  localparam int  F = 65536;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_push = 0;
  logic in_full;
  logic signed [31:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic out_pop = 0, out_empty, out_begin_subpath;
  logic signed [31:0] out_screen_x0, out_screen_y0, out_screen_x1, out_screen_y1;
  int fail_count, pending;
  int cycles = 0;
  bit calm = 0, rx_hold_req = 0;
  longint win_l, win_t, win_r, win_b;

  segment_clip_and_screen_map_core uut (.*);
  segment_clip_and_screen_map_checker chk (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_clip_and_screen_map_core_test: FAIL");
      $finish;
    end
  end

  // receiver: random pops, plus a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold = 600;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 0;
      end else
        out_pop <= rst_n && (calm || $urandom_range(99) >= 24);
    end
  end

  task automatic write_reg(scmap_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_push <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_window(longint l, t, r, b, sx, sy, ox, oy);
    drain();
    win_l = 32'(l); win_t = 32'(t); win_r = 32'(r); win_b = 32'(b);
    win_l = signed'(32'(l)); win_t = signed'(32'(t));
    win_r = signed'(32'(r)); win_b = signed'(32'(b));
    write_reg(scmap_pkg::REG_CLIP_LEFT, 32'(l));
    write_reg(scmap_pkg::REG_CLIP_TOP, 32'(t));
    write_reg(scmap_pkg::REG_CLIP_RIGHT, 32'(r));
    write_reg(scmap_pkg::REG_CLIP_BOTTOM, 32'(b));
    write_reg(scmap_pkg::REG_SCALE_X, 32'(sx));
    write_reg(scmap_pkg::REG_SCALE_Y, 32'(sy));
    write_reg(scmap_pkg::REG_OFFSET_X, 32'(ox));
    write_reg(scmap_pkg::REG_OFFSET_Y, 32'(oy));
  endtask

  task automatic send_seg(logic [31:0] x0, y0, x1, y1);
    while (!calm && $urandom_range(99) < 24) begin
      in_push <= 0;
      @(negedge clk);
    end
    in_push <= 1;
    in_start_x <= x0; in_start_y <= y0; in_end_x <= x1; in_end_y <= y1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] near_coord(longint lo, longint hi);
    longint a, b, w, v;
    a = lo < hi ? lo : hi;
    b = lo < hi ? hi : lo;
    w = (b - a) / 2 + 64;
    if (w > 64'sd1 << 31) w = 64'sd1 << 31;
    v = a - w + longint'($urandom_range(32'(b - a + 2 * w > 64'hFFFFFFFF ?
                                            64'hFFFFFFFF : b - a + 2 * w)));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic random_segs(int n);
    logic [31:0] x0, y0, x1, y1;
    int mode;
    repeat (n) begin
      mode = $urandom_range(99);
      x0 = near_coord(win_l, win_r); y0 = near_coord(win_t, win_b);
      x1 = near_coord(win_l, win_r); y1 = near_coord(win_t, win_b);
      if (mode < 10) begin
        x0 = $urandom; y0 = $urandom; x1 = $urandom; y1 = $urandom;
      end else if (mode < 16) x1 = x0;
      else if (mode < 22) y1 = y0;
      else if (mode < 26) begin
        x1 = x0; y1 = y0;
      end
      send_seg(x0, y0, x1, y1);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    win_l = 0; win_t = 0; win_r = F; win_b = F;
    random_segs(300);

    set_window(-10 * F, -10 * F, 10 * F, 10 * F, 2 * F, -3 * F / 2, 100 * F, 50 * F);
    send_seg(-F, -F, F, 2 * F);                 // fully inside
    send_seg(-20 * F, 0, 0, F);                 // crosses left edge
    send_seg(-20 * F, -20 * F, 20 * F, 20 * F); // cut at both ends
    send_seg(0, 0, 30 * F, 5 * F);              // leaves through right
    send_seg(30 * F, 0, 40 * F, F);             // fully outside
    send_seg(F, -20 * F, F, 20 * F);            // vertical, parallel inside
    send_seg(20 * F, -F, 20 * F, F);            // vertical, parallel outside
    send_seg(-F, 3 * F, F, 3 * F);              // horizontal inside
    send_seg(2 * F, 2 * F, 2 * F, 2 * F);       // single point inside
    send_seg(50 * F, 2 * F, 50 * F, 2 * F);     // single point outside
    send_seg(10 * F, 10 * F, 10 * F, 10 * F);   // point on the corner
    send_seg(5 * F, 0, 10 * F, 0);              // ends on the edge
    send_seg(20 * F, 20 * F, -20 * F, -20 * F); // reversed direction
    send_seg(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_seg(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_seg(32'h7fffffff, 0, 32'h80000000, 0);
    send_seg(0, 32'h80000000, 0, 32'h7fffffff);
    send_seg(-15 * F, 0, 0, 15 * F);            // cuts the corner: enters left, leaves bottom
    random_segs(200);

    set_window(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    rx_hold_req = 1;  // results back up, input stalls
    random_segs(200);

    set_window(5 * F, 0, -5 * F, 3 * F, F, F, 0, 0);  // inverted horizontally
    random_segs(100);
    in_push <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    random_segs(100);

    set_window(0, 0, 1, 1, 0, F, 32'h80000000, 32'h7fffffff);
    calm = 1;
    random_segs(200);
    calm = 0;

    repeat (2) begin
      set_window($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      random_segs(50);
      set_window(-$urandom_range(1 << 24), -$urandom_range(1 << 24),
                 $urandom_range(1 << 24), $urandom_range(1 << 24),
                 $urandom, $urandom, $urandom, $urandom);
      random_segs(100);
    end

    drain();
    if (fail_count == 0)
      $display("segment_clip_and_screen_map_core_test: PASS");
    else
      $display("segment_clip_and_screen_map_core_test: FAIL");
    $finish;
  end
endmodule
